[rtl/tcsr_pkg.sv]
// Package for the touch controller SPI register block.
// Holds item types, command and register codes, and the page 3 power-on table.
// No dependencies.
`default_nettype none

package tcsr_pkg;

  localparam int PAGE_BYTES = 128;

  typedef enum logic [1:0] {
    CMD_SPI        = 2'd0,
    CMD_CS_RELEASE = 2'd1,
    CMD_TOUCH      = 2'd2
  } cmd_t;

  // banks
  localparam logic [7:0] BANK_PAGE  = 8'h03;
  localparam logic [7:0] BANK_COORD = 8'hFC;
  localparam logic [7:0] BANK_SYS   = 8'hFF;

  // register ids (index >> 1)
  localparam logic [6:0] ID_BANK      = 7'h00;
  localparam logic [6:0] ID_MODE      = 7'h05;
  localparam logic [6:0] ID_PEN_STAT  = 7'h09;
  localparam logic [6:0] ID_WR_A      = 7'h0D;
  localparam logic [6:0] ID_WR_B      = 7'h0E;
  localparam logic [6:0] ID_Y_FIRST   = 7'h0B;
  localparam logic [6:0] ID_COORD_END = 7'h15;

  localparam logic [7:0]  MODE_COMPAT   = 8'h00;
  localparam logic [7:0]  MODE_RESET    = 8'h01;
  localparam logic [15:0] WORD_RELEASED = 16'h7000;
  localparam logic [11:0] Y_RELEASED    = 12'hFFF;
  localparam logic [7:0]  PEN_UP        = 8'h40;
  localparam logic [7:0]  PEN_DOWN      = 8'h80;
  localparam logic [7:0]  WR_B_RESET    = 8'hAD;
  localparam logic [7:0]  WR_KEEP_MASK  = 8'h03;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  spi_byte;
    logic [11:0] touch_x;
    logic [11:0] touch_y;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] mode_value;
    logic       compat_entered;
  } result_t;

  // Power-on contents of the read-only bytes of page 3.
  function automatic logic [7:0] page3_rom(input logic [6:0] id);
    logic [7:0] b;
    case (id)
      7'h02:   b = 8'h18;
      7'h03:   b = 8'h87;
      7'h04:   b = 8'h22;
      7'h05:   b = 8'h04;
      7'h06:   b = 8'h20;
      7'h0F:   b = 8'hA0;
      7'h10:   b = 8'h88;
      7'h11:   b = 8'h81;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/touch_controller_spi_registers_unit.sv]
// Top level of the touch controller SPI register block.
// Depends on tcsr_pkg, tcsr_in_stage and tcsr_core.
`default_nettype none

// One item per clock, sustained, while out_stall is low. An accepted item
// is held in the input register, then the register update and result are
// computed in a single pass and land in the result register, which drives
// the ports. A stalled result holds while one more item waits in the input
// register. Page 3 is a constant table plus three register bytes, two of
// them writable over SPI, so reset is immediate and needs no clearing
// pass. Once mode 0 is written the block ignores every command until reset.
module touch_controller_spi_registers_unit
  import tcsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  spi_byte,
  input  wire logic [11:0] touch_x,
  input  wire logic [11:0] touch_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_data,
  output logic [7:0]       mode_value,
  output logic             compat_entered
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    consume;
  result_t result;

  assign in_item.cmd      = cmd;
  assign in_item.spi_byte = spi_byte;
  assign in_item.touch_x  = touch_x;
  assign in_item.touch_y  = touch_y;

  tcsr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  tcsr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .consume    (consume),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign read_data      = result.read_data;
  assign mode_value     = result.mode_value;
  assign compat_entered = result.compat_entered;

endmodule

`default_nettype wire

[rtl/tcsr_in_stage.sv]
// Input register of the touch controller SPI register block.
// Depends on tcsr_pkg.
`default_nettype none

module tcsr_in_stage
  import tcsr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  input  wire logic  consume,
  output logic       item_valid,
  output item_t      item
);

  logic load;

  assign in_stall = item_valid && !consume;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

[rtl/tcsr_core.sv]
// Register state, per-item update logic and result register.
// Depends on tcsr_pkg.
`default_nettype none

module tcsr_core
  import tcsr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  input  wire item_t item,
  output logic       consume,
  output logic       out_valid,
  input  wire logic  out_stall,
  output result_t    result
);

  logic [7:0]  mode_reg, mode_reg_next;
  logic [7:0]  bank_sel, bank_sel_next;
  logic [7:0]  reg_index, reg_index_next;
  logic        in_transfer, in_transfer_next;
  logic [7:0]  read_hold, read_hold_next;
  logic [15:0] coord_x_word, coord_x_word_next;
  logic [15:0] coord_y_word, coord_y_word_next;
  logic [7:0]  pen_stat, pen_stat_next;   // page 3 id 0x09
  logic [7:0]  wr_a, wr_a_next;           // page 3 id 0x0D
  logic [7:0]  wr_b, wr_b_next;           // page 3 id 0x0E
  logic        entered;

  logic [6:0]  id;
  logic        rd;
  logic [7:0]  page_byte;
  logic        released;
  logic        pen_changed;
  logic [15:0] new_x, new_y;

  assign consume = item_valid && (!out_valid || !out_stall);

  assign id       = reg_index[7:1];
  assign rd       = reg_index[0];
  assign released = (item.touch_y == Y_RELEASED);
  assign pen_changed = wr_b[0] ^ released;

  always_comb begin
    if (int'(id) >= PAGE_BYTES) begin
      page_byte = 8'h00;
    end else if (id == ID_PEN_STAT) begin
      page_byte = pen_stat;
    end else if (id == ID_WR_A) begin
      page_byte = wr_a;
    end else if (id == ID_WR_B) begin
      page_byte = wr_b;
    end else begin
      page_byte = page3_rom(id);
    end
  end

  always_comb begin
    new_x = released ? WORD_RELEASED : {item.touch_x, 4'h0};
    new_y = released ? WORD_RELEASED : {item.touch_y, 4'h0};
    new_x[15] = new_x[15] | pen_changed;
    new_y[15] = new_y[15] | pen_changed;
  end

  always_comb begin
    mode_reg_next     = mode_reg;
    bank_sel_next     = bank_sel;
    reg_index_next    = reg_index;
    in_transfer_next  = in_transfer;
    read_hold_next    = read_hold;
    coord_x_word_next = coord_x_word;
    coord_y_word_next = coord_y_word;
    pen_stat_next     = pen_stat;
    wr_a_next         = wr_a;
    wr_b_next         = wr_b;
    entered           = 1'b0;

    if (mode_reg != MODE_COMPAT) begin
      case (item.cmd)
        CMD_SPI: begin
          if (!in_transfer) begin
            reg_index_next   = item.spi_byte;
            in_transfer_next = 1'b1;
          end else begin
            reg_index_next = reg_index + 8'd2;
            if (id == ID_BANK) begin
              if (rd) begin
                read_hold_next = bank_sel;
              end else begin
                bank_sel_next = item.spi_byte;
              end
            end else if (bank_sel == BANK_PAGE) begin
              if (rd) begin
                read_hold_next = page_byte;
              end else if (id == ID_WR_A) begin
                wr_a_next = (wr_a & WR_KEEP_MASK) | (item.spi_byte & ~WR_KEEP_MASK);
              end else if (id == ID_WR_B) begin
                wr_b_next = (wr_b & WR_KEEP_MASK) | (item.spi_byte & ~WR_KEEP_MASK);
              end
            end else if (bank_sel == BANK_COORD && rd) begin
              // reading either byte clears the pen-change flag of that word
              if (id < ID_Y_FIRST) begin
                read_hold_next       = id[0] ? coord_x_word[15:8] : coord_x_word[7:0];
                coord_x_word_next[15] = 1'b0;
              end else if (id < ID_COORD_END) begin
                read_hold_next       = id[0] ? coord_y_word[15:8] : coord_y_word[7:0];
                coord_y_word_next[15] = 1'b0;
              end else begin
                read_hold_next = 8'h00;
              end
            end else if (bank_sel == BANK_SYS && id == ID_MODE) begin
              if (rd) begin
                read_hold_next = mode_reg;
              end else begin
                mode_reg_next = item.spi_byte;
                if (item.spi_byte == MODE_COMPAT) begin
                  in_transfer_next = 1'b0;
                  reg_index_next   = reg_index;
                  entered          = 1'b1;
                end
              end
            end
          end
        end
        CMD_CS_RELEASE: begin
          in_transfer_next = 1'b0;
        end
        CMD_TOUCH: begin
          coord_x_word_next = new_x;
          coord_y_word_next = new_y;
          pen_stat_next     = released ? PEN_UP : PEN_DOWN;
          wr_b_next         = {wr_b[7:1], released};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_RESET;
      bank_sel     <= 8'h00;
      reg_index    <= 8'h00;
      in_transfer  <= 1'b0;
      read_hold    <= 8'h00;
      coord_x_word <= 16'h0000;
      coord_y_word <= 16'h0000;
      pen_stat     <= PEN_UP;
      wr_a         <= 8'h00;
      wr_b         <= WR_B_RESET;
    end else if (consume) begin
      mode_reg     <= mode_reg_next;
      bank_sel     <= bank_sel_next;
      reg_index    <= reg_index_next;
      in_transfer  <= in_transfer_next;
      read_hold    <= read_hold_next;
      coord_x_word <= coord_x_word_next;
      coord_y_word <= coord_y_word_next;
      pen_stat     <= pen_stat_next;
      wr_a         <= wr_a_next;
      wr_b         <= wr_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      result.read_data      <= read_hold_next;
      result.mode_value     <= mode_reg_next;
      result.compat_entered <= entered;
    end
  end

endmodule

`default_nettype wire

[rtl/tcsr_checker.sv]
// Port-level checks for the touch controller SPI register block.
// Bound to touch_controller_spi_registers_unit; depends on tcsr_pkg.
`default_nettype none

module tcsr_checker
  import tcsr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] read_data,
  input wire logic [7:0] mode_value,
  input wire logic       compat_entered
);

  // no result may survive a reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // entering compatibility mode must show mode 0 in the same result
  a_compat_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && compat_entered |-> mode_value == MODE_COMPAT)
    else $error("compat_entered with nonzero mode");

  // with no result pending the input side never stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data)
      && $stable(mode_value) && $stable(compat_entered))
    else $error("stalled result changed");

endmodule

bind touch_controller_spi_registers_unit tcsr_checker u_tcsr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .read_data      (read_data),
  .mode_value     (mode_value),
  .compat_entered (compat_entered)
);

`default_nettype wire
